@@ hw/rtl/lbp_pkg.sv @@
package lbp_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int FILE_W    = 8;
	localparam int BLOCK_W   = 20;
	localparam int TAG_W     = FILE_W + BLOCK_W;
	localparam int SLOT_W    = 4;

	typedef enum logic [2:0] {
		K_ACCESS = 3'd0,
		K_ALLOC  = 3'd1,
		K_REMOVE = 3'd2,
		K_PIN    = 3'd3,
		K_UNPIN  = 3'd4,
		K_DIRTY  = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_HIT        = 3'd0,
		ST_MISS_FREE  = 3'd1,
		ST_EVICT      = 3'd2,
		ST_ALL_PINNED = 3'd3,
		ST_REMOVED    = 3'd4,
		ST_ABSENT     = 3'd5,
		ST_REFUSED    = 3'd6,
		ST_FLAGS      = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_APPLY
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic apply;
	} cmd_t;

	typedef struct packed {
		logic last;
	} sts_t;

endpackage

@@ hw/rtl/lbp_ram.sv @@
module lbp_ram import lbp_pkg::*; #(
	parameter int WIDTH = TAG_W,
	parameter int DEPTH = SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/lbp_ctrl.sv @@
module lbp_ctrl import lbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/lbp_dp.sv @@
module lbp_dp import lbp_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [2:0]         kind,
	input  logic [FILE_W-1:0]  file_id,
	input  logic [BLOCK_W-1:0] block_index,
	output logic               done,
	output logic [2:0]         status,
	output logic [SLOT_W-1:0]  slot,
	output logic               fetch_needed,
	output logic               writeback_valid,
	output logic [FILE_W-1:0]  writeback_file,
	output logic [BLOCK_W-1:0] writeback_block
);

	localparam int IW = $clog2(SLOTS);
	localparam int AW = $clog2(SLOTS);

	logic [2:0]         kind_q;
	logic [FILE_W-1:0]  fid_q;
	logic [BLOCK_W-1:0] blk_q;

	logic [SLOTS-1:0] valid_q, pinned_q, dirty_q;
	logic [AW-1:0]    age_q [SLOTS];

	logic [IW-1:0]    idx_q;
	logic [IW-1:0]    cmp_idx_s1;
	logic             cmp_vld_s1;
	logic [TAG_W-1:0] rd_tag;

	logic             hit_q, free_q, best_q;
	logic [IW-1:0]    hit_idx_q, free_idx_q, best_idx_q;
	logic [AW-1:0]    best_age_q;
	logic [TAG_W-1:0] best_tag_q;

	logic          ram_we;
	logic [IW-1:0] sel;
	logic [AW-1:0] sel_age;
	logic          slot_en, front_en, front_all, rem_en, fill_en;
	logic          mark_dirty, set_pin, clr_pin;
	status_t       st;
	logic          fetch, wbv;

	assign sts.last = (idx_q == IW'(SLOTS - 1));

	lbp_ram #(
		.WIDTH(TAG_W),
		.DEPTH(SLOTS)
	) u_tag_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(sel),
		.wr_data({fid_q, blk_q}),
		.rd_en  (cmd.scan),
		.rd_addr(idx_q),
		.rd_data(rd_tag)
	);

	// scan address and compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			best_q     <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan;
			if (cmd.load) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				best_q <= 1'b0;
			end else begin
				if (cmd.scan) begin
					idx_q <= idx_q + 1'b1;
				end
				if (cmp_vld_s1) begin
					if (valid_q[cmp_idx_s1] && rd_tag == {fid_q, blk_q} && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (!valid_q[cmp_idx_s1] && !free_q) begin
						free_q <= 1'b1;
					end
					if (valid_q[cmp_idx_s1] && !pinned_q[cmp_idx_s1] &&
							(!best_q || age_q[cmp_idx_s1] > best_age_q)) begin
						best_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= idx_q;
		if (cmd.load) begin
			kind_q <= kind;
			fid_q  <= file_id;
			blk_q  <= block_index;
		end
		if (cmp_vld_s1) begin
			if (valid_q[cmp_idx_s1] && rd_tag == {fid_q, blk_q} && !hit_q) begin
				hit_idx_q <= cmp_idx_s1;
			end
			if (!valid_q[cmp_idx_s1] && !free_q) begin
				free_idx_q <= cmp_idx_s1;
			end
			if (valid_q[cmp_idx_s1] && !pinned_q[cmp_idx_s1] &&
					(!best_q || age_q[cmp_idx_s1] > best_age_q)) begin
				best_idx_q <= cmp_idx_s1;
				best_age_q <= age_q[cmp_idx_s1];
				best_tag_q <= rd_tag;
			end
		end
	end

	// decision for the transaction
	always_comb begin
		sel        = '0;
		slot_en    = 1'b0;
		front_en   = 1'b0;
		front_all  = 1'b0;
		rem_en     = 1'b0;
		fill_en    = 1'b0;
		mark_dirty = 1'b0;
		set_pin    = 1'b0;
		clr_pin    = 1'b0;
		st         = ST_ABSENT;
		fetch      = 1'b0;
		wbv        = 1'b0;
		priority if (kind_q == K_ACCESS || kind_q == K_ALLOC) begin
			if (hit_q) begin
				sel      = hit_idx_q;
				slot_en  = 1'b1;
				front_en = 1'b1;
				st       = ST_HIT;
			end else if (free_q) begin
				sel       = free_idx_q;
				slot_en   = 1'b1;
				front_en  = 1'b1;
				front_all = 1'b1;
				fill_en   = 1'b1;
				fetch     = 1'b1;
				st        = ST_MISS_FREE;
			end else if (best_q) begin
				sel      = best_idx_q;
				slot_en  = 1'b1;
				front_en = 1'b1;
				fill_en  = 1'b1;
				fetch    = 1'b1;
				wbv      = dirty_q[best_idx_q];
				st       = ST_EVICT;
			end else begin
				st = ST_ALL_PINNED;
			end
			mark_dirty = (kind_q == K_ALLOC) && slot_en;
		end else if (hit_q && (kind_q == K_REMOVE || kind_q == K_PIN ||
				kind_q == K_UNPIN || kind_q == K_DIRTY)) begin
			sel     = hit_idx_q;
			slot_en = 1'b1;
			if (kind_q == K_REMOVE) begin
				if (pinned_q[hit_idx_q]) begin
					st = ST_REFUSED;
				end else begin
					rem_en = 1'b1;
					st     = ST_REMOVED;
				end
			end else begin
				set_pin    = (kind_q == K_PIN);
				clr_pin    = (kind_q == K_UNPIN);
				mark_dirty = (kind_q == K_DIRTY);
				st         = ST_FLAGS;
			end
		end else begin
			st = ST_ABSENT;
		end
	end

	assign sel_age = age_q[sel];
	assign ram_we  = cmd.apply && fill_en;

	// per-slot flags and recency ranks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			pinned_q <= '0;
			dirty_q  <= '0;
			for (int j = 0; j < SLOTS; j++) begin
				age_q[j] <= '0;
			end
		end else if (cmd.apply) begin
			for (int j = 0; j < SLOTS; j++) begin
				if (front_en && IW'(j) != sel && valid_q[j] &&
						(front_all || age_q[j] < sel_age)) begin
					age_q[j] <= age_q[j] + 1'b1;
				end else if (rem_en && valid_q[j] && age_q[j] > sel_age) begin
					age_q[j] <= age_q[j] - 1'b1;
				end
			end
			if (front_en || rem_en) begin
				age_q[sel] <= '0;
			end
			if (fill_en) begin
				valid_q[sel]  <= 1'b1;
				pinned_q[sel] <= 1'b0;
				dirty_q[sel]  <= mark_dirty;
			end
			if (rem_en) begin
				valid_q[sel]  <= 1'b0;
				pinned_q[sel] <= 1'b0;
				dirty_q[sel]  <= 1'b0;
			end
			if (set_pin) begin
				pinned_q[sel] <= 1'b1;
			end
			if (clr_pin) begin
				pinned_q[sel] <= 1'b0;
			end
			if (mark_dirty && !fill_en) begin
				dirty_q[sel] <= 1'b1;
			end
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.apply;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			status          <= st;
			slot            <= slot_en ? SLOT_W'(sel) : '0;
			fetch_needed    <= fetch;
			writeback_valid <= wbv;
			writeback_file  <= wbv ? best_tag_q[TAG_W-1:BLOCK_W] : '0;
			writeback_block <= wbv ? best_tag_q[BLOCK_W-1:0] : '0;
		end
	end

endmodule

@@ hw/rtl/lru_buffer_pool_with_pinning.sv @@
// LRU buffer pool with pinning: tag store of SLOTS entries kept in recency order.
// Command channel: a transaction is accepted at a rising edge with start high
// and busy low; kind, file_id and block_index are sampled at that edge.
// Kinds: access, allocate, remove, pin, unpin, mark dirty.
// Result channel: done is high for exactly one cycle with status, slot,
// fetch_needed and the write-back fields; the receiver cannot hold it off.
// Sequence: the accepting edge starts the tag scan, then come a drain state
// and an apply state, and done rises after the apply state. busy drops in
// the cycle that done is high, so a new command may be accepted then.
// The scan reads the tag RAM one slot per cycle; the drain state covers
// the last compare and the apply state updates ranks and flags.
// One transaction is in flight at a time.
// Reset clears all valid, pinned, dirty flags and ranks at once; the tag RAM
// needs no clearing since only valid entries are matched. The block is ready
// once reset is released.
module lru_buffer_pool_with_pinning import lbp_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         kind,
	input  logic [FILE_W-1:0]  file_id,
	input  logic [BLOCK_W-1:0] block_index,
	output logic               done,
	output logic [2:0]         status,
	output logic [SLOT_W-1:0]  slot,
	output logic               fetch_needed,
	output logic               writeback_valid,
	output logic [FILE_W-1:0]  writeback_file,
	output logic [BLOCK_W-1:0] writeback_block
);

	cmd_t cmd;
	sts_t sts;

	lbp_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	lbp_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.kind           (kind),
		.file_id        (file_id),
		.block_index    (block_index),
		.done           (done),
		.status         (status),
		.slot           (slot),
		.fetch_needed   (fetch_needed),
		.writeback_valid(writeback_valid),
		.writeback_file (writeback_file),
		.writeback_block(writeback_block)
	);

endmodule
